// ===== hw/rtl/tcc_pkg.sv =====
// ---------------------------------------------------------------------------
// tcc_pkg
// shared types, field widths and character codes of the text console engine
// ---------------------------------------------------------------------------
package tcc_pkg;

   localparam int DEF_COLUMNS   = 80;
   localparam int DEF_ROWS      = 25;
   localparam int DEF_TAB_WIDTH = 8;

   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CADR_W = 11;
   localparam int LOC_W  = 11;
   localparam int CELL_W = 16;

   typedef logic [CMD_W-1:0]  command_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [ATTR_W-1:0] attr_type;

   localparam command_type CMD_PUT   = 2'd0;
   localparam command_type CMD_CLEAR = 2'd1;
   localparam command_type CMD_READ  = 2'd2;

   localparam char_type CHAR_BS    = 8'h08;
   localparam char_type CHAR_TAB   = 8'h09;
   localparam char_type CHAR_LF    = 8'h0A;
   localparam char_type CHAR_CR    = 8'h0D;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_DEL   = 8'h7F;

   localparam attr_type ATTR_RESET = 8'h0F;

   typedef struct packed {
      logic     put;
      logic     home;
      char_type char_code;
   } tcc_cursor_cmd_type;

   typedef struct packed {
      logic cell_write;
      logic scroll;
   } tcc_cursor_stat_type;

endpackage

// ===== hw/rtl/tcc_cell_mem.sv =====
// ---------------------------------------------------------------------------
// tcc_cell_mem
// character cell store, one write port and one registered read port
// ---------------------------------------------------------------------------
module tcc_cell_mem
   import tcc_pkg::*;
#(
   parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] store_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tcc_cursor.sv =====
// ---------------------------------------------------------------------------
// tcc_cursor
// cursor column, row and tab phase with the put-byte decode
// ---------------------------------------------------------------------------
module tcc_cursor
   import tcc_pkg::*;
#(
   parameter int COLUMNS   = DEF_COLUMNS,
   parameter int ROWS      = DEF_ROWS,
   parameter int TAB_WIDTH = DEF_TAB_WIDTH,
   localparam int ADDR_W   = $clog2(COLUMNS * ROWS)
) (
   input  logic                clock,
   input  logic                reset,
   input  tcc_cursor_cmd_type  cmd,
   output tcc_cursor_stat_type stat,
   output logic [ADDR_W-1:0]   wr_addr,
   output logic [LOC_W-1:0]    location
);

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int PH_W   = $clog2(TAB_WIDTH);
   localparam int NC_W   = $clog2(COLUMNS + TAB_WIDTH + 1);
   localparam int WIDE_W = (ADDR_W > LOC_W) ? ADDR_W : LOC_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PH_W-1:0]  phase_ff, phase_in;

   logic [NC_W-1:0]   col_step;
   logic [PH_W-1:0]   phase_step;
   logic              row_step;
   logic [WIDE_W-1:0] lin;

   always_comb begin
      col_step        = NC_W'(col_ff);
      phase_step      = phase_ff;
      row_step        = 1'b0;
      stat.cell_write = 1'b0;
      case (cmd.char_code)
         CHAR_BS: begin
            if (col_ff != '0) begin
               col_step   = NC_W'(col_ff) - NC_W'(1);
               phase_step = (phase_ff == '0) ? PH_W'(TAB_WIDTH - 1) : phase_ff - PH_W'(1);
            end
         end
         CHAR_TAB: begin
            col_step   = NC_W'(col_ff) + NC_W'(TAB_WIDTH) - NC_W'(phase_ff);
            phase_step = '0;
         end
         CHAR_CR: begin
            col_step   = '0;
            phase_step = '0;
         end
         CHAR_LF: begin
            col_step   = '0;
            phase_step = '0;
            row_step   = 1'b1;
         end
         default: begin
            if (cmd.char_code >= CHAR_SPACE && cmd.char_code <= CHAR_DEL) begin
               stat.cell_write = 1'b1;
               col_step        = NC_W'(col_ff) + NC_W'(1);
               phase_step      = (phase_ff == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_ff + PH_W'(1);
            end
         end
      endcase
      if (col_step >= NC_W'(COLUMNS)) begin
         col_step   = '0;
         phase_step = '0;
         row_step   = 1'b1;
      end
      stat.scroll = row_step && (row_ff == ROW_W'(ROWS - 1));

      col_in   = col_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      if (cmd.home) begin
         col_in   = '0;
         row_in   = '0;
         phase_in = '0;
      end else if (cmd.put) begin
         col_in   = col_step[COL_W-1:0];
         phase_in = phase_step;
         if (row_step && !stat.scroll) begin
            row_in = row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         phase_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
      end
   end

   assign lin      = WIDE_W'(row_ff) * WIDE_W'(COLUMNS) + WIDE_W'(col_ff);
   assign wr_addr  = lin[ADDR_W-1:0];
   assign location = lin[LOC_W-1:0];

endmodule

// ===== hw/rtl/text_console_char_engine.sv =====
// ---------------------------------------------------------------------------
// text_console_char_engine
// text console character engine: cell store, cursor and command sequencer
// ---------------------------------------------------------------------------
// req channel: one command per transaction, tuser carries the command, tdata
// the byte to put and the cell address to read. rsp channel: one transaction
// per command with the cursor location after it and the cell read (zero for
// anything but a read). csr channel: writes the attribute byte, always ready.
// One command is in work at a time; req_tready is high only while idle.
// Put, read and unused commands go from acceptance to ST_RESP, which loads the output register.
// A put that scrolls: ST_SCROLL, one cell copied per cycle through the single
// write port of the cell store and the bottom row blanked, then ST_RESP.
// Clear: ST_FILL, one cell blanked per cycle, then ST_RESP.
// After reset the store is blanked with the reset attribute in ST_FILL
// before req_tready rises.
// A result waiting on a stalled receiver holds in the output register; the
// engine then holds its next result and takes no new command until it moves.
// ---------------------------------------------------------------------------
module text_console_char_engine
   import tcc_pkg::*;
#(
   parameter int COLUMNS   = DEF_COLUMNS,
   parameter int ROWS      = DEF_ROWS,
   parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,   // command
   input  logic [23:0]       req_tdata,   // char_code, cell_address, zero fill
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // cursor_location, cell_data, zero fill
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ATTR_W-1:0] csr_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int MOVE   = CELLS - COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SCAN_W = $clog2(CELLS + 1);
   localparam int WIDE_W = (ADDR_W > CADR_W) ? ADDR_W : CADR_W;

   typedef enum logic [3:0] {
      ST_FILL   = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCROLL = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              copy_ff, copy_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic [CELL_W-1:0] blank_ff, blank_in;
   attr_type          attr_ff;
   logic              fill_resp_ff, fill_resp_in;
   logic              rd_sel_ff, rd_sel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_data_ff, rsp_data_in;
   logic [LOC_W-1:0]  rsp_loc_ff, rsp_loc_in;

   command_type         req_command;
   char_type            req_char;
   logic [CADR_W-1:0]   req_addr;
   logic [WIDE_W-1:0]   req_addr_wide;
   logic                accept;
   tcc_cursor_cmd_type  cur_cmd;
   tcc_cursor_stat_type cur_stat;
   logic [ADDR_W-1:0]   cur_addr;
   logic [LOC_W-1:0]    cur_loc;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CELL_W-1:0]   wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [CELL_W-1:0]   rd_data;
   logic [SCAN_W-1:0]   scan_src;

   assign req_command   = req_tuser;
   assign req_char      = req_tdata[7:0];
   assign req_addr      = req_tdata[18:8];
   assign req_addr_wide = WIDE_W'(req_addr);
   assign req_tready    = (state_ff == ST_IDLE);
   assign accept        = req_tvalid && req_tready;
   assign csr_ready     = 1'b1;
   assign scan_src      = scan_ff + SCAN_W'(COLUMNS);

   assign cur_cmd.put       = accept && (req_command == CMD_PUT);
   assign cur_cmd.home      = accept && (req_command == CMD_CLEAR);
   assign cur_cmd.char_code = req_char;

   tcc_cursor #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_cursor (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cur_cmd),
      .stat     (cur_stat),
      .wr_addr  (cur_addr),
      .location (cur_loc)
   );

   tcc_cell_mem #(
      .DEPTH (CELLS)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      copy_in      = copy_ff;
      dst_in       = dst_ff;
      blank_in     = blank_ff;
      fill_resp_in = fill_resp_ff;
      rd_sel_in    = rd_sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_loc_in   = rsp_loc_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_addr;
      wr_data      = {attr_ff, req_char};
      rd_en        = 1'b0;
      rd_addr      = req_addr_wide[ADDR_W-1:0];
      case (state_ff)
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[ADDR_W-1:0];
            wr_data = blank_ff;
            scan_in = scan_ff + SCAN_W'(1);
            if (scan_ff == SCAN_W'(CELLS - 1)) begin
               state_in = fill_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rd_sel_in = 1'b0;
               state_in  = ST_RESP;
               case (req_command)
                  CMD_PUT: begin
                     wr_en = cur_stat.cell_write;
                     if (cur_stat.scroll) begin
                        state_in = ST_SCROLL;
                        scan_in  = '0;
                        copy_in  = 1'b0;
                     end
                  end
                  CMD_CLEAR: begin
                     blank_in     = {attr_ff, CHAR_SPACE};
                     scan_in      = '0;
                     fill_resp_in = 1'b1;
                     state_in     = ST_FILL;
                  end
                  CMD_READ: begin
                     if (32'(req_addr) < 32'(CELLS)) begin
                        rd_en     = 1'b1;
                        rd_sel_in = 1'b1;
                     end
                  end
                  default: begin
                     rd_sel_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            if (copy_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff;
               wr_data = rd_data;
            end
            if (scan_ff < SCAN_W'(MOVE)) begin
               rd_en   = 1'b1;
               rd_addr = scan_src[ADDR_W-1:0];
               dst_in  = scan_ff[ADDR_W-1:0];
               copy_in = 1'b1;
               scan_in = scan_ff + SCAN_W'(1);
            end else begin
               copy_in = 1'b0;
               if (!copy_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = scan_ff[ADDR_W-1:0];
                  wr_data = {attr_ff, CHAR_SPACE};
                  scan_in = scan_ff + SCAN_W'(1);
                  if (scan_ff == SCAN_W'(CELLS - 1)) begin
                     state_in = ST_RESP;
                  end
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_sel_ff ? rd_data : '0;
               rsp_loc_in   = cur_loc;
               fill_resp_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         scan_ff      <= '0;
         copy_ff      <= 1'b0;
         blank_ff     <= {ATTR_RESET, CHAR_SPACE};
         attr_ff      <= ATTR_RESET;
         fill_resp_ff <= 1'b0;
         rd_sel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         copy_ff      <= copy_in;
         blank_ff     <= blank_in;
         fill_resp_ff <= fill_resp_in;
         rd_sel_ff    <= rd_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            attr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      dst_ff      <= dst_in;
      rsp_data_ff <= rsp_data_in;
      rsp_loc_ff  <= rsp_loc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff, rsp_loc_ff};

endmodule

// ===== hw/rtl/tcc_checker.sv =====
// ---------------------------------------------------------------------------
// tcc_checker
// port-level checks on the text console engine, bound to the top level
// ---------------------------------------------------------------------------
module tcc_checker
   import tcc_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   localparam int CELLS = COLUMNS * ROWS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while one is in work");

   a_loc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CELLS > 2048) || (32'(rsp_tdata[10:0]) < 32'(CELLS)))
      else $error("cursor location beyond the screen");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity straight after reset");

endmodule

bind text_console_char_engine tcc_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
